>>> hdl/mid_pkg.sv
package mid_pkg;

    localparam int DIFF_W  = 32;
    localparam int SIZE_W  = 31;
    localparam int MASK_W  = 3;
    localparam int AXES    = 3;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int DIST_W  = 33;
    localparam int TAG_W   = AXES * DIFF_W;
    localparam int ADDR_W  = 2;

    typedef logic [ADDR_W-1:0] reg_addr_t;

    localparam reg_addr_t REG_BOX_X = 2'd0;
    localparam reg_addr_t REG_BOX_Y = 2'd1;
    localparam reg_addr_t REG_BOX_Z = 2'd2;
    localparam reg_addr_t REG_MASK  = 2'd3;

    localparam logic [SIZE_W-1:0] BOX_RESET  = 31'd65536;
    localparam logic [MASK_W-1:0] MASK_RESET = 3'd0;

endpackage

>>> hdl/minimum_image_distance.sv
// channel  | direction | tdata fields (low bit up)                       | tuser/tlast
// s_       | in        | diff_x[31:0] diff_y[63:32] diff_z[95:64]         | none
// m_       | out       | folded_x folded_y folded_z distance[128:96], pad | none
// cfg_     | in        | box_size_x/y/z (idx 0..2), periodic_mask (idx 3) | -
//
// One word per cycle in and out while the sink takes them. Registers: 33 in
// the per-axis remainder pipeline (one quotient bit per stage), 4 for magnitude,
// square and the two-step sum, 32 in the square-root pipeline, 1 for output.
// Synchronous active-low reset clears all valid bits and loads the register
// defaults. When the output word is held by the sink, every stage holds.
module minimum_image_distance
    import mid_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [95:0]         s_tdata,   // diff_x, diff_y, diff_z
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [135:0]        m_tdata,   // folded_x, folded_y, folded_z, distance, zero pad
    input  logic                cfg_we,
    input  reg_addr_t           cfg_addr,
    input  logic [SIZE_W-1:0]   cfg_wdata
);

    logic [SIZE_W-1:0] box_reg [AXES];
    logic [MASK_W-1:0] mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AXES; i++) begin
                box_reg[i] <= BOX_RESET;
            end
            mask_reg <= MASK_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_BOX_X: box_reg[0] <= cfg_wdata;
                REG_BOX_Y: box_reg[1] <= cfg_wdata;
                REG_BOX_Z: box_reg[2] <= cfg_wdata;
                REG_MASK:  mask_reg   <= cfg_wdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    logic m_tvalid_reg;
    logic adv;
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    logic                     fold_valid [AXES];
    logic signed [DIFF_W-1:0] folded     [AXES];

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        mid_fold u_fold (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (adv),
            .in_valid   (s_tvalid),
            .in_diff    ($signed(s_tdata[a*DIFF_W +: DIFF_W])),
            .box_size   (box_reg[a]),
            .periodic   (mask_reg[a]),
            .out_valid  (fold_valid[a]),
            .out_folded (folded[a])
        );
    end

    // magnitude, square, two-step sum
    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic [DIFF_W-1:0] mag_reg [AXES];
    logic [SQ_W-1:0]   sq_reg  [AXES];
    logic [SQ_W-1:0]   s3a_reg, s3b_reg, sum_reg;
    logic [TAG_W-1:0]  t1_reg, t2_reg, t3_reg, t4_reg;
    logic [TAG_W-1:0]  fold_tag;

    assign fold_tag = {folded[2], folded[1], folded[0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= fold_valid[0];
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < AXES; i++) begin
                mag_reg[i] <= folded[i][DIFF_W-1] ? DIFF_W'(-folded[i])
                                                  : DIFF_W'(folded[i]);
                sq_reg[i]  <= mag_reg[i] * mag_reg[i];
            end
            s3a_reg <= sq_reg[0] + sq_reg[1];
            s3b_reg <= sq_reg[2];
            sum_reg <= s3a_reg + s3b_reg;
            t1_reg  <= fold_tag;
            t2_reg  <= t1_reg;
            t3_reg  <= t2_reg;
            t4_reg  <= t3_reg;
        end
    end

    logic              root_valid;
    logic [ROOT_W-1:0] root;
    logic [TAG_W-1:0]  root_tag;

    mid_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v4_reg),
        .in_n      (sum_reg),
        .in_tag    (t4_reg),
        .out_valid (root_valid),
        .out_root  (root),
        .out_tag   (root_tag)
    );

    logic [135:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= root_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= {7'd0, DIST_W'(root), root_tag};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> hdl/mid_fold.sv
module mid_fold
    import mid_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [DIFF_W-1:0] in_diff,
    input  logic [SIZE_W-1:0]        box_size,
    input  logic                     periodic,
    output logic                     out_valid,
    output logic signed [DIFF_W-1:0] out_folded
);

    logic                     valid_reg [DIFF_W];
    logic signed [DIFF_W-1:0] d_reg     [DIFF_W];
    logic [DIFF_W-1:0]        a_reg     [DIFF_W];
    logic [SIZE_W-1:0]        rem_reg   [DIFF_W];

    logic                     valid_src [DIFF_W];
    logic signed [DIFF_W-1:0] d_src     [DIFF_W];
    logic [DIFF_W-1:0]        a_src     [DIFF_W];
    logic [SIZE_W-1:0]        rem_src   [DIFF_W];

    logic [DIFF_W-1:0] in_mag;
    assign in_mag = in_diff[DIFF_W-1] ? DIFF_W'(-in_diff) : DIFF_W'(in_diff);

    // one quotient bit per stage: restoring division of |d| by the box size
    for (genvar k = 0; k < DIFF_W; k++) begin : g_step
        logic [DIFF_W-1:0] shifted;
        logic              ge;
        logic [DIFF_W-1:0] diff_sub;

        if (k == 0) begin : g_first
            assign valid_src[k] = in_valid;
            assign d_src[k]     = in_diff;
            assign a_src[k]     = in_mag;
            assign rem_src[k]   = '0;
        end else begin : g_next
            assign valid_src[k] = valid_reg[k-1];
            assign d_src[k]     = d_reg[k-1];
            assign a_src[k]     = a_reg[k-1];
            assign rem_src[k]   = rem_reg[k-1];
        end

        assign shifted  = {rem_src[k], a_src[k][DIFF_W-1]};
        assign ge       = shifted >= {1'b0, box_size};
        assign diff_sub = shifted - {1'b0, box_size};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_src[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[k]   <= d_src[k];
                a_reg[k]   <= {a_src[k][DIFF_W-2:0], 1'b0};
                rem_reg[k] <= ge ? diff_sub[SIZE_W-1:0] : shifted[SIZE_W-1:0];
            end
        end
    end

    logic                     fin_valid_reg;
    logic signed [DIFF_W-1:0] fin_reg;

    logic [SIZE_W-1:0]        r;
    logic                     round_up;
    logic signed [DIFF_W:0]   fm;
    logic signed [DIFF_W:0]   signed_fm;
    logic signed [DIFF_W-1:0] fin_next;

    always_comb begin
        r         = rem_reg[DIFF_W-1];
        round_up  = {r, 1'b0} >= {1'b0, box_size};
        fm        = round_up ? ($signed({2'b00, r}) - $signed({2'b00, box_size}))
                             : $signed({2'b00, r});
        signed_fm = d_reg[DIFF_W-1][DIFF_W-1] ? -fm : fm;
        // free axis or zero-size box: pass the difference through
        if (!periodic || box_size == '0) begin
            fin_next = d_reg[DIFF_W-1];
        end else begin
            fin_next = signed_fm[DIFF_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (en) begin
            fin_valid_reg <= valid_reg[DIFF_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_reg <= fin_next;
        end
    end

    assign out_valid  = fin_valid_reg;
    assign out_folded = fin_reg;

endmodule

>>> hdl/mid_isqrt.sv
module mid_isqrt
    import mid_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SQ_W-1:0]   in_n,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [TAG_W-1:0]  out_tag
);

    logic              valid_reg [ROOT_W];
    logic [SQ_W-1:0]   n_reg     [ROOT_W];
    logic [REM_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [TAG_W-1:0]  tag_reg   [ROOT_W];

    logic              valid_src [ROOT_W];
    logic [SQ_W-1:0]   n_src     [ROOT_W];
    logic [REM_W-1:0]  rem_src   [ROOT_W];
    logic [ROOT_W-1:0] root_src  [ROOT_W];
    logic [TAG_W-1:0]  tag_src   [ROOT_W];

    // one root bit per stage, two radicand bits shifted in each time
    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [REM_W+1:0] shifted;
        logic [REM_W+1:0] trial;
        logic             ge;
        logic [REM_W+1:0] rem_sub;

        if (k == 0) begin : g_first
            assign valid_src[k] = in_valid;
            assign n_src[k]     = in_n;
            assign rem_src[k]   = '0;
            assign root_src[k]  = '0;
            assign tag_src[k]   = in_tag;
        end else begin : g_next
            assign valid_src[k] = valid_reg[k-1];
            assign n_src[k]     = n_reg[k-1];
            assign rem_src[k]   = rem_reg[k-1];
            assign root_src[k]  = root_reg[k-1];
            assign tag_src[k]   = tag_reg[k-1];
        end

        assign shifted = {rem_src[k], n_src[k][SQ_W-1:SQ_W-2]};
        assign trial   = {2'b00, root_src[k], 2'b01};
        assign ge      = shifted >= trial;
        assign rem_sub = shifted - trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_src[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k]    <= {n_src[k][SQ_W-3:0], 2'b00};
                rem_reg[k]  <= ge ? rem_sub[REM_W-1:0] : shifted[REM_W-1:0];
                root_reg[k] <= {root_src[k][ROOT_W-2:0], ge};
                tag_reg[k]  <= tag_src[k];
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_tag   = tag_reg[ROOT_W-1];

endmodule

>>> test/tb_top.sv
module tb_top;
    import mid_pkg::*;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [95:0]         s_tdata = '0;     // diff_x, diff_y, diff_z
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [135:0]        m_tdata;          // folded_x, folded_y, folded_z, distance, pad
    logic                cfg_we = 1'b0;
    reg_addr_t           cfg_addr = REG_BOX_X;
    logic [SIZE_W-1:0]   cfg_wdata = '0;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [31:0]       fz;
        logic [31:0]       fy;
        logic [31:0]       fx;
    } fold_result_t;

    fold_result_t expected_q[$];
    logic [SIZE_W-1:0] box_len [AXES];
    logic [MASK_W-1:0] wrap_mask;
    int mismatches = 0;
    int words_checked = 0;
    int words_sent = 0;
    bit send_gaps = 1'b1;
    bit sink_stalls = 1'b1;

    minimum_image_distance uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200000000;
        $display("simulation failed");
        $finish;
    end

    // round half away from zero, then subtract the box multiple
    function automatic longint fold_diff(longint d, logic [SIZE_W-1:0] s);
        longint unsigned mag;
        longint unsigned q;
        longint shift;
        mag = (d < 0) ? -d : d;
        q = (2 * mag + s) / (2 * longint'(s));
        shift = q * s;
        return (d < 0) ? d + shift : d - shift;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned r = 0;
        longint unsigned bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic fold_result_t predict_fold(logic [95:0] w);
        fold_result_t res;
        longint unsigned sum = 0;
        longint d;
        longint unsigned mag;
        logic [31:0] f [AXES];
        for (int i = 0; i < AXES; i++) begin
            d = longint'(signed'(w[32*i +: 32]));
            if (wrap_mask[i] && box_len[i] != 0) d = fold_diff(d, box_len[i]);
            f[i] = d[31:0];
            mag = (d < 0) ? -d : d;
            sum += mag * mag;
        end
        res.fx = f[0];
        res.fy = f[1];
        res.fz = f[2];
        res.distance = DIST_W'(floor_root(sum));
        return res;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (sink_stalls) m_tready <= ($urandom_range(99) >= 33);
            else m_tready <= 1'b1;
            if (m_tvalid && m_tready) begin
                fold_result_t got;
                fold_result_t want;
                got = m_tdata[128:0];
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %h", got);
                end else begin
                    want = expected_q.pop_front();
                    words_checked++;
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: fx %h/%h fy %h/%h fz %h/%h dist %h/%h",
                                want.fx, got.fx, want.fy, got.fy, want.fz, got.fz,
                                want.distance, got.distance);
                    end
                end
            end
        end
    end

    task automatic send_word(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        if (send_gaps) begin
            while ($urandom_range(99) < 33) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= {dz, dy, dx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.push_back(predict_fold({dz, dy, dx}));
        words_sent++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(reg_addr_t a, logic [SIZE_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= v;
        @(posedge aclk);
        if (a == REG_MASK) wrap_mask = v[MASK_W-1:0];
        else box_len[a] = v;
    endtask

    task automatic setup(logic [SIZE_W-1:0] bx, logic [SIZE_W-1:0] by,
                         logic [SIZE_W-1:0] bz, logic [MASK_W-1:0] m);
        drain();
        write_reg(REG_BOX_X, bx);
        write_reg(REG_BOX_Y, by);
        write_reg(REG_BOX_Z, bz);
        write_reg(REG_MASK, m);
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_defaults;
        send_word(32'h0003_0000, 32'hFFFC_0000, 32'h0);
        send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    endtask

    task automatic test_directed_folds;
        setup(31'h0001_0000, 31'h0004_0000, 31'h7FFF_FFFF, 3'b111);
        send_word(32'h0000_8000, 32'h0002_0000, 32'h4000_0000);  // exact half ties on x and y
        send_word(32'hFFFF_8000, 32'hFFFE_0000, 32'hC000_0000);
        send_word(32'h0001_8000, 32'h0006_0000, 32'h3FFF_FFFF);
        send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(32'h0, 32'h0, 32'h0);
        setup(31'd0, 31'd1, 31'd3, 3'b111);                       // zero box on x acts free
        send_word(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
        send_word(32'h7FFF_FFFF, 32'h8000_0001, 32'h0000_0005);
        setup(31'h0002_0000, 31'h0002_0000, 31'h0002_0000, 3'b010);
        send_word(32'h0003_0000, 32'h0003_0000, 32'h0003_0000);
        send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    endtask

    function automatic logic [31:0] rand_diff(logic [SIZE_W-1:0] s);
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(s) - (s >> 1);
            2: return (s >> 1) * (32'($urandom_range(20)) - 10);
            default: return {$urandom_range(1) ? 16'hFFFF : 16'h0, 16'($urandom)};
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] rand_box;
        case ($urandom_range(3))
            0: return SIZE_W'($urandom_range(1, 255));
            1: return SIZE_W'($urandom_range(32'h0001_0000, 32'h0040_0000));
            2: return SIZE_W'($urandom & 32'h7FFF_FFFF);
            default: return SIZE_W'($urandom_range(1, 16)) << 16;
        endcase
    endfunction

    task automatic test_random_phases;
        for (int p = 0; p < 13; p++) begin
            setup(rand_box(), rand_box(), rand_box(), MASK_W'($urandom_range(7)));
            send_gaps = (p != 6);
            sink_stalls = (p != 6);
            for (int k = 0; k < 100; k++)
                send_word(rand_diff(box_len[0]), rand_diff(box_len[1]),
                          rand_diff(box_len[2]));
        end
        send_gaps = 1'b1;
        sink_stalls = 1'b1;
    endtask

    initial begin
        wrap_mask = MASK_RESET;
        for (int i = 0; i < AXES; i++) box_len[i] = BOX_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed_folds();
        test_random_phases();
        drain();
        $display("sent %0d words over the reset defaults and 16 register settings",
                 words_sent);
        $display("checked %0d results, with and without stalls on both sides",
                 words_checked);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
